// ----- design/fwcs_pkg.sv -----
// ----------------------------------------------------------------------------
// fwcs_pkg
// Types and constants shared by the coordinate queue and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package fwcs_pkg;

  localparam int COORD_W  = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int OCC_W    = 5;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- design/fwcs_in_if.sv -----
// ----------------------------------------------------------------------------
// fwcs_in_if
// Request channel of the coordinate queue: operation code and pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwcs_in_if import fwcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;

  modport source (output valid, output operation, output x_coord, output y_coord,
                  input ready);
  modport sink (input valid, input operation, input x_coord, input y_coord,
                output ready);
endinterface

`default_nettype wire

// ----- design/fwcs_out_if.sv -----
// ----------------------------------------------------------------------------
// fwcs_out_if
// Response channel of the coordinate queue: status, pair, position, occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwcs_out_if import fwcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COORD_W-1:0]  out_x;
  logic [COORD_W-1:0]  out_y;
  logic [POS_W-1:0]    position;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output out_x, output out_y,
                  output position, output occupancy, input ready);
  modport sink (input valid, input status, input out_x, input out_y,
                input position, input occupancy, output ready);
endinterface

`default_nettype wire

// ----- design/fifo_with_coordinate_search.sv -----
// ----------------------------------------------------------------------------
// fifo_with_coordinate_search
// First-in first-out queue of coordinate pairs built as a shifting row of
// cells, with an associative search that reports the match nearest the head.
// Enqueue, dequeue and no-op: result registered in the cycle after the
// transaction, one transaction per cycle sustained while responses are taken.
// Search: no transaction is taken while the search is in progress; the cells
// register their compare first, and the first match is then encoded into the
// registered result.
// Reset (synchronous, active low) empties the queue and clears the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_coordinate_search import fwcs_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  fwcs_in_if.sink    in_if,
  fwcs_out_if.source out_if
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {S_IDLE, S_SEARCH} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic              out_valid_r;
  status_t           status_r;
  coord_t            out_x_r;
  coord_t            out_y_r;
  logic [POS_W-1:0]  position_r;
  logic [OCC_W-1:0]  occupancy_r;
  coord_t            key_x_r;
  coord_t            key_y_r;

  op_t               op;
  logic              accept;
  logic              full;
  logic              empty;
  logic              do_enq;
  logic              do_deq;
  logic              do_search;

  coord_t            cell_x [QUEUE_DEPTH];
  coord_t            cell_y [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] match;
  logic              any_match;
  logic [POS_W-1:0]  first_pos;

  assign op        = op_t'(in_if.operation);
  assign in_if.ready = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign accept    = in_if.valid && in_if.ready;
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_enq    = accept && (op == OP_ENQ) && !full;
  assign do_deq    = accept && (op == OP_DEQ) && !empty;
  assign do_search = accept && (op == OP_SEARCH);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    coord_t nx;
    coord_t ny;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nx = '0;
      assign ny = '0;
    end else begin : g_mid
      assign nx = cell_x[i+1];
      assign ny = cell_y[i+1];
    end
    fwcs_cell u_cell (
      .clk       (clk),
      .load_en   (do_enq && (count_r == CNT_W'(i))),
      .shift_en  (do_deq),
      .search_en (do_search),
      .occupied  (CNT_W'(i) < count_r),
      .load_x    (in_if.x_coord),
      .load_y    (in_if.y_coord),
      .next_x    (nx),
      .next_y    (ny),
      .x         (cell_x[i]),
      .y         (cell_y[i]),
      .match     (match[i])
    );
  end

  assign any_match = |match;

  always_comb begin
    int first;
    first = 0;
    for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
      if (match[k]) begin
        first = k;
      end
    end
    first_pos = POS_W'(first);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_x_r    <= '0;
            out_y_r    <= '0;
            position_r <= '0;
            unique case (op)
              OP_ENQ: begin
                out_valid_r <= 1'b1;
                if (full) begin
                  status_r    <= ST_FULL;
                  occupancy_r <= OCC_W'(count_r);
                end else begin
                  status_r    <= ST_OK;
                  count_r     <= count_r + 1'b1;
                  occupancy_r <= OCC_W'(count_r + 1'b1);
                end
              end
              OP_DEQ: begin
                out_valid_r <= 1'b1;
                if (empty) begin
                  status_r    <= ST_EMPTY;
                  occupancy_r <= '0;
                end else begin
                  status_r    <= ST_OK;
                  out_x_r     <= cell_x[0];
                  out_y_r     <= cell_y[0];
                  count_r     <= count_r - 1'b1;
                  occupancy_r <= OCC_W'(count_r - 1'b1);
                end
              end
              OP_SEARCH: begin
                key_x_r <= in_if.x_coord;
                key_y_r <= in_if.y_coord;
                state_r <= S_SEARCH;
              end
              OP_NOP: begin
                out_valid_r <= 1'b1;
                status_r    <= ST_OK;
                occupancy_r <= OCC_W'(count_r);
              end
              default: begin
                out_valid_r <= 1'b1;
                status_r    <= ST_OK;
                occupancy_r <= OCC_W'(count_r);
              end
            endcase
          end
        end
        S_SEARCH: begin
          out_valid_r <= 1'b1;
          occupancy_r <= OCC_W'(count_r);
          state_r     <= S_IDLE;
          if (any_match) begin
            status_r   <= ST_OK;
            out_x_r    <= key_x_r;
            out_y_r    <= key_y_r;
            position_r <= first_pos;
          end else begin
            status_r   <= ST_NOTFOUND;
            out_x_r    <= '0;
            out_y_r    <= '0;
            position_r <= '0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.status    = status_r;
  assign out_if.out_x     = out_x_r;
  assign out_if.out_y     = out_y_r;
  assign out_if.position  = position_r;
  assign out_if.occupancy = occupancy_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_search_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |=> out_valid_r && state_r == S_IDLE)
    else $error("search did not produce a result");

  a_no_accept_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> !in_if.ready)
    else $error("transaction accepted during search");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_deq |=> count_r == $past(count_r) - 1'b1)
    else $error("dequeue did not lower the count");

endmodule

`default_nettype wire

// ----- design/fwcs_cell.sv -----
// ----------------------------------------------------------------------------
// fwcs_cell
// One queue slot: holds a pair, takes its neighbour's pair on a dequeue and
// registers whether it matches a search key.
// ----------------------------------------------------------------------------
`default_nettype none

module fwcs_cell import fwcs_pkg::*; (
  input  logic   clk,
  input  logic   load_en,
  input  logic   shift_en,
  input  logic   search_en,
  input  logic   occupied,
  input  coord_t load_x,
  input  coord_t load_y,
  input  coord_t next_x,
  input  coord_t next_y,
  output coord_t x,
  output coord_t y,
  output logic   match
);

  coord_t x_r;
  coord_t y_r;
  logic   match_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      x_r <= load_x;
      y_r <= load_y;
    end else if (shift_en) begin
      x_r <= next_x;
      y_r <= next_y;
    end
    if (search_en) begin
      match_r <= occupied && (x_r == load_x) && (y_r == load_y);
    end
  end

  assign x     = x_r;
  assign y     = y_r;
  assign match = match_r;

endmodule

`default_nettype wire

// ----- bench/fwcs_result_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwcs_result_check
// Watches both channels of the coordinate queue. Every accepted request is run
// through an independent model of the queue and its search, and every accepted
// response is compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module fwcs_result_check import fwcs_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  fwcs_in_if   in_mon,
  fwcs_out_if  out_mon,
  output int   mismatch_count,
  output int   results_awaited
);

  typedef struct packed {
    status_t          status;
    coord_t           x;
    coord_t           y;
    logic [POS_W-1:0] position;
    logic [OCC_W-1:0] occupancy;
  } queue_result_t;

  coord_t        stored_x [QUEUE_DEPTH];
  coord_t        stored_y [QUEUE_DEPTH];
  int unsigned   head_slot;
  int unsigned   tail_slot;
  int unsigned   held;
  queue_result_t predicted_results [$];

  function automatic int unsigned next_slot(int unsigned slot);
    return (slot + 1 == QUEUE_DEPTH) ? 0 : slot + 1;
  endfunction

  function automatic queue_result_t apply_operation(op_t op, coord_t x, coord_t y);
    queue_result_t res;
    int unsigned   slot;
    bit            hit;
    res = '0;
    res.status = ST_OK;
    hit = 1'b0;
    case (op)
      OP_ENQ: begin
        if (held == QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stored_x[tail_slot] = x;
          stored_y[tail_slot] = y;
          tail_slot = next_slot(tail_slot);
          held++;
        end
      end
      OP_DEQ: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.x = stored_x[head_slot];
          res.y = stored_y[head_slot];
          head_slot = next_slot(head_slot);
          held--;
        end
      end
      OP_SEARCH: begin
        res.status = ST_NOTFOUND;
        slot = head_slot;
        for (int k = 0; k < held && !hit; k++) begin
          if (stored_x[slot] == x && stored_y[slot] == y) begin
            hit = 1'b1;
            res.status = ST_OK;
            res.x = x;
            res.y = y;
            res.position = POS_W'(k);
          end
          slot = next_slot(slot);
        end
      end
      default: begin
      end
    endcase
    res.occupancy = OCC_W'(held);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      head_slot = 0;
      tail_slot = 0;
      held = 0;
      mismatch_count = 0;
      predicted_results.delete();
      results_awaited <= 0;
    end else begin
      // A response leaving in the same cycle belongs to an earlier request.
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unrequested response, status", 32'(out_mon.status), '0);
        end else begin
          want = predicted_results.pop_front();
          if (out_mon.status !== want.status)
            report_mismatch("status", 32'(out_mon.status), 32'(want.status));
          if (out_mon.out_x !== want.x)
            report_mismatch("out_x", out_mon.out_x, want.x);
          if (out_mon.out_y !== want.y)
            report_mismatch("out_y", out_mon.out_y, want.y);
          if (out_mon.position !== want.position)
            report_mismatch("position", 32'(out_mon.position), 32'(want.position));
          if (out_mon.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(out_mon.occupancy), 32'(want.occupancy));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predicted_results.push_back(apply_operation(op_t'(in_mon.operation),
                                                    in_mon.x_coord, in_mon.y_coord));
      end
      results_awaited <= predicted_results.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the coordinate queue: a directed opening that covers empty,
// full and corner-value cases, then random enqueue, dequeue, search and no-op
// traffic with random idling on both channels. Checking is done by
// fwcs_result_check; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;
  import fwcs_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } coord_pair_t;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   results_awaited;

  coord_pair_t recent_pairs [$];

  fwcs_in_if  in_ch ();
  fwcs_out_if out_ch ();

  fifo_with_coordinate_search #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  fwcs_result_check #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatch_count  (mismatch_count),
    .results_awaited (results_awaited)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[fifo_with_coordinate_search] ERROR");
    $finish;
  end

  function automatic coord_t pick_coord();
    coord_t corners [4];
    corners = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return coord_t'($urandom_range(0, 3));
      default:    return corners[$urandom_range(0, 3)];
    endcase
  endfunction

  // Holds the request until the queue takes it; the transaction completes at
  // the edge on which this task returns.
  task automatic send_item(op_t op, coord_t x, coord_t y);
    coord_pair_t p;
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.x_coord   <= x;
    in_ch.y_coord   <= y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_ENQ) begin
      p.x = x;
      p.y = y;
      recent_pairs.push_back(p);
      if (recent_pairs.size() > 24) void'(recent_pairs.pop_front());
    end
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_awaited != 0) @(posedge clk);
  endtask

  // Response side: random back-pressure, opening with a long hold-off so that
  // the queue output backs up and the request channel stalls.
  initial begin
    int hold;
    int r;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    repeat (150) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        out_ch.ready <= 1'b1;
        hold = $urandom_range(1, 8);
      end else if (r < 52) begin
        out_ch.ready <= 1'b1;
        hold = $urandom_range(20, 60);
      end else if (r < 88) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(1, 3);
      end else if (r < 97) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(4, 12);
      end else begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(30, 100);
      end
      repeat (hold) @(posedge clk);
    end
  end

  initial begin
    int          r;
    int          k;
    int          gap;
    int          waited;
    bit          filling;
    bit          steady;
    op_t         op;
    coord_pair_t p;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_NOP;
    in_ch.x_coord   <= '0;
    in_ch.y_coord   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue, no-op, corner pairs and searches that hit and narrowly miss.
    send_item(OP_DEQ, '0, '0);
    send_item(OP_SEARCH, '0, '0);
    send_item(OP_NOP, '1, '1);
    send_item(OP_ENQ, '0, '0);
    send_item(OP_ENQ, '1, '1);
    send_item(OP_ENQ, '0, '1);
    send_item(OP_ENQ, '1, '0);
    send_item(OP_SEARCH, '0, '0);
    send_item(OP_SEARCH, '1, '0);
    send_item(OP_SEARCH, '1, 32'h0000_0001);
    // Fill to the last slot, overflow it, then find the entry furthest from the head.
    for (int i = 0; i < 11; i++) begin
      send_item(OP_ENQ, coord_t'(32'h0000_0100 + i), ~coord_t'(32'h0000_0100 + i));
    end
    send_item(OP_ENQ, 32'h1234_5678, 32'h9abc_def0);
    send_item(OP_ENQ, '0, '0);
    send_item(OP_SEARCH, 32'h1234_5678, 32'h9abc_def0);
    send_item(OP_DEQ, '0, '0);
    wait_for_results();

    filling = 1'b1;
    steady  = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        filling = $urandom_range(0, 1);
        steady  = ($urandom_range(0, 3) == 0);
      end
      if (n % 300 == 299) wait_for_results();

      r = $urandom_range(0, 99);
      if (filling)
        op = (r < 55) ? OP_ENQ : (r < 70) ? OP_DEQ : (r < 95) ? OP_SEARCH : OP_NOP;
      else
        op = (r < 20) ? OP_ENQ : (r < 65) ? OP_DEQ : (r < 95) ? OP_SEARCH : OP_NOP;

      p.x = pick_coord();
      p.y = pick_coord();
      if (op == OP_SEARCH && recent_pairs.size() != 0) begin
        k = $urandom_range(0, 9);
        if (k < 7) p = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
        if (k == 7) p.y = p.y ^ (coord_t'(1) << $urandom_range(0, 31));
      end
      send_item(op, p.x, p.y);

      if (!steady) begin
        r = $urandom_range(0, 99);
        gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 2) :
              (r < 98) ? $urandom_range(3, 8) : $urandom_range(15, 40);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    in_ch.valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (results_awaited != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && results_awaited == 0) begin
      $display("[fifo_with_coordinate_search] OK");
    end else begin
      if (results_awaited != 0) $display("%0d responses never arrived", results_awaited);
      $display("[fifo_with_coordinate_search] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/fwcs_pkg.sv
design/fwcs_in_if.sv
design/fwcs_out_if.sv
design/fwcs_cell.sv
design/fifo_with_coordinate_search.sv
bench/fwcs_result_check.sv
bench/tb_top.sv
